// ===== hdl/bicubic_image_scaler_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef BICUBIC_IMAGE_SCALER_CORE_ASSERT_SVH
`define BICUBIC_IMAGE_SCALER_CORE_ASSERT_SVH

// Property checked at every rising edge outside reset.
`define BISC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define BISC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== hdl/bisc_pkg.sv =====
`timescale 1ns / 1ps
package bisc_pkg;
  localparam int COORD_W = 12;
  localparam int CHAN_W  = 8;
  localparam int SIZE_W  = 9;
  localparam int STEP_W  = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HORIZONTAL_STEP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VERTICAL_STEP   = 2'd3;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;
endpackage

// ===== hdl/bicubic_image_scaler_core.sv =====
`timescale 1ns / 1ps
// Bicubic image scaler. A load command (cmd low) with coordinates inside the
// maximum size writes one RGB pixel into the frame memory in the accepting
// cycle and leaves busy low, so loads may be issued every cycle. A compute
// command holds busy high through the position multiplies, sixteen reads of
// the single-ported frame memory (one window tap per cycle), then the last
// row pass and the column pass through the four-stage cubic pipelines. The
// result appears on out_red/out_green/out_blue for exactly one cycle with
// out_valid high, in the cycle in which busy falls; there is no back-pressure,
// so capture it then. The next command may be accepted at the end of that
// cycle; computes never overlap. Write configuration only while busy is low.
// Reading a frame entry that was never loaded returns undefined data.
module bicubic_image_scaler_core #(
  parameter int MAX_SOURCE_WIDTH     = 256,
  parameter int MAX_SOURCE_HEIGHT    = 256,
  parameter int STEP_FRACTION_BITS   = 16,
  parameter int WEIGHT_FRACTION_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cmd,
  input  logic [bisc_pkg::COORD_W-1:0]   coord_x,
  input  logic [bisc_pkg::COORD_W-1:0]   coord_y,
  input  logic [bisc_pkg::CHAN_W-1:0]    in_red,
  input  logic [bisc_pkg::CHAN_W-1:0]    in_green,
  input  logic [bisc_pkg::CHAN_W-1:0]    in_blue,
  output logic                           out_valid,
  output logic [bisc_pkg::CHAN_W-1:0]    out_red,
  output logic [bisc_pkg::CHAN_W-1:0]    out_green,
  output logic [bisc_pkg::CHAN_W-1:0]    out_blue,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bisc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bisc_pkg::STEP_W-1:0]    cfg_data
);
  import bisc_pkg::*;

  localparam int WF  = WEIGHT_FRACTION_BITS;
  localparam int SF  = STEP_FRACTION_BITS;
  localparam int PW  = WF + CHAN_W + 3;
  localparam int XW  = $clog2(MAX_SOURCE_WIDTH);
  localparam int YW  = $clog2(MAX_SOURCE_HEIGHT);
  localparam int AW  = XW + YW;
  localparam int PRW = COORD_W + STEP_W;
  localparam int BW  = PRW - SF;
  localparam int TW  = BW + 2;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MUL   = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0] state;
  logic [SIZE_W-1:0] source_width, source_height;
  logic [STEP_W-1:0] horizontal_step, vertical_step;
  logic [COORD_W-1:0] cx, cy;
  logic [PRW-1:0] posx, posy;
  logic [WF-1:0] tx, ty;
  logic [3:0] cnt;
  logic [1:0] rcnt;
  logic rd_en, rd_vld;
  logic [1:0] rd_i;
  logic [AW-1:0] rd_addr;
  pixel_t mem [2**AW];
  pixel_t rdata;
  logic wr_en;
  logic signed [TW-1:0] weff, heff, tapx, tapy, clx, cly;
  logic signed [PW-1:0] pnew [3];
  logic signed [PW-1:0] rbuf [3][3];
  logic signed [PW-1:0] cbuf [3][3];
  logic signed [PW-1:0] cin  [3][4];
  logic signed [PW-1:0] rout [3];
  logic signed [PW-1:0] q    [3];
  logic [CHAN_W-1:0] sat [3];
  logic [3:0] vld, iscol;
  logic launch_row, launch_col, row_out, col_out;
  logic [WF-1:0] tf_in;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = ~busy;
  assign wr_en = start && !busy && (cmd == CMD_LOAD)
              && ({1'b0, coord_x} < (COORD_W + 1)'(MAX_SOURCE_WIDTH))
              && ({1'b0, coord_y} < (COORD_W + 1)'(MAX_SOURCE_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width    <= SIZE_W'(256);
      source_height   <= SIZE_W'(256);
      horizontal_step <= STEP_W'(32768);
      vertical_step   <= STEP_W'(32768);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:    source_width    <= cfg_data[SIZE_W-1:0];
        REG_SOURCE_HEIGHT:   source_height   <= cfg_data[SIZE_W-1:0];
        REG_HORIZONTAL_STEP: horizontal_step <= cfg_data;
        REG_VERTICAL_STEP:   vertical_step   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective image size, saturated to 2..max.
  always_comb begin
    if (source_width < SIZE_W'(2)) weff = TW'(2);
    else if (TW'(source_width) > TW'(MAX_SOURCE_WIDTH)) weff = TW'(MAX_SOURCE_WIDTH);
    else weff = TW'(source_width);
    if (source_height < SIZE_W'(2)) heff = TW'(2);
    else if (TW'(source_height) > TW'(MAX_SOURCE_HEIGHT)) heff = TW'(MAX_SOURCE_HEIGHT);
    else heff = TW'(source_height);
  end

  generate
    if (SF >= WF) begin : g_tf_cut
      assign tx = posx[SF-1 -: WF];
      assign ty = posy[SF-1 -: WF];
    end else begin : g_tf_pad
      assign tx = {posx[SF-1:0], {(WF - SF){1'b0}}};
      assign ty = {posy[SF-1:0], {(WF - SF){1'b0}}};
    end
  endgenerate

  // Tap position base-1+i, clamped to the image.
  always_comb begin
    tapx = $signed({2'b00, posx[PRW-1:SF]}) + $signed(TW'(cnt[1:0])) - TW'(1);
    tapy = $signed({2'b00, posy[PRW-1:SF]}) + $signed(TW'(cnt[3:2])) - TW'(1);
    if (tapx < 0) clx = '0;
    else if (tapx > weff - TW'(1)) clx = weff - TW'(1);
    else clx = tapx;
    if (tapy < 0) cly = '0;
    else if (tapy > heff - TW'(1)) cly = heff - TW'(1);
    else cly = tapy;
    rd_addr = {cly[YW-1:0], clx[XW-1:0]};
  end

  assign rd_en = (state == ST_READ);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{coord_y[YW-1:0], coord_x[XW-1:0]}] <= '{red: in_red, green: in_green, blue: in_blue};
    end else if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  assign pnew[0] = $signed(PW'({rdata.red,   {WF{1'b0}}}));
  assign pnew[1] = $signed(PW'({rdata.green, {WF{1'b0}}}));
  assign pnew[2] = $signed(PW'({rdata.blue,  {WF{1'b0}}}));

  assign launch_row = rd_vld && (rd_i == 2'd3);
  assign row_out    = vld[3] && !iscol[3];
  assign col_out    = vld[3] && iscol[3];
  assign launch_col = row_out && (rcnt == 2'd3);
  assign tf_in      = launch_col ? ty : tx;

  genvar c;
  generate
    for (c = 0; c < 3; c++) begin : g_lane
      always_comb begin
        if (launch_col) begin
          cin[c][0] = cbuf[c][0];
          cin[c][1] = cbuf[c][1];
          cin[c][2] = cbuf[c][2];
          cin[c][3] = rout[c];
        end else begin
          cin[c][0] = rbuf[c][0];
          cin[c][1] = rbuf[c][1];
          cin[c][2] = rbuf[c][2];
          cin[c][3] = pnew[c];
        end
        q[c] = rout[c] >>> WF;
        if (q[c] < 0) sat[c] = '0;
        else if (q[c] > PW'(255)) sat[c] = 8'd255;
        else sat[c] = q[c][CHAN_W-1:0];
      end

      bisc_cubic #(.WF(WF), .PW(PW)) u_cubic (
        .clk(clk),
        .p0(cin[c][0]), .p1(cin[c][1]), .p2(cin[c][2]), .p3(cin[c][3]),
        .tf(tf_in),
        .r(rout[c])
      );

      always_ff @(posedge clk) begin
        if (rd_vld) begin
          rbuf[c][0] <= rbuf[c][1];
          rbuf[c][1] <= rbuf[c][2];
          rbuf[c][2] <= pnew[c];
        end
        if (row_out) begin
          cbuf[c][0] <= cbuf[c][1];
          cbuf[c][1] <= cbuf[c][2];
          cbuf[c][2] <= rout[c];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      rcnt      <= '0;
      rd_vld    <= 1'b0;
      vld       <= '0;
      iscol     <= '0;
      out_valid <= 1'b0;
    end else begin
      rd_vld    <= rd_en;
      vld       <= {vld[2:0], launch_row || launch_col};
      iscol     <= {iscol[2:0], launch_col};
      out_valid <= 1'b0;
      if (row_out) rcnt <= rcnt + 2'd1;
      case (state)
        ST_IDLE: begin
          if (start && (cmd == CMD_COMPUTE)) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          cnt   <= '0;
          rcnt  <= '0;
          state <= ST_READ;
        end
        ST_READ: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (col_out) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_i <= cnt[1:0];
    if (state == ST_IDLE && start) begin
      cx <= coord_x;
      cy <= coord_y;
    end
    if (state == ST_MUL) begin
      posx <= cx * horizontal_step;
      posy <= cy * vertical_step;
    end
    if (col_out) begin
      out_red   <= sat[0];
      out_green <= sat[1];
      out_blue  <= sat[2];
    end
  end
endmodule

// ===== hdl/bisc_cubic.sv =====
`timescale 1ns / 1ps
// Catmull-Rom cubic, four register stages, one multiplication in each of the last three.
module bisc_cubic #(
  parameter int WF = 8,
  parameter int PW = 19
) (
  input  logic                 clk,
  input  logic signed [PW-1:0] p0,
  input  logic signed [PW-1:0] p1,
  input  logic signed [PW-1:0] p2,
  input  logic signed [PW-1:0] p3,
  input  logic [WF-1:0]        tf,
  output logic signed [PW-1:0] r
);
  localparam int CW = PW + 5;
  localparam int MW = CW + WF + 1;

  logic signed [CW-1:0] a1, b1, c1, a2, s2, s1;
  logic signed [PW-1:0] q1, q2, q3;
  logic [WF-1:0]        t1, t2, t3;
  logic signed [MW-1:0] m2, m3, m4;
  logic signed [CW-1:0] e0, e1, e2, e3;

  assign e0 = CW'(p0);
  assign e1 = CW'(p1);
  assign e2 = CW'(p2);
  assign e3 = CW'(p3);

  assign m2 = c1 * $signed({1'b0, t1});
  assign m3 = s2 * $signed({1'b0, t2});
  assign m4 = s1 * $signed({1'b0, t3});

  always_ff @(posedge clk) begin
    a1 <= e2 - e0;
    b1 <= (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
    c1 <= (e1 - e2) + ((e1 - e2) <<< 1) + e3 - e0;
    q1 <= p1;
    t1 <= tf;
    s2 <= b1 + CW'(m2 >>> WF);
    a2 <= a1;
    q2 <= q1;
    t2 <= t1;
    s1 <= a2 + CW'(m3 >>> WF);
    q3 <= q2;
    t3 <= t2;
    r  <= q3 + PW'(m4 >>> (WF + 1));
  end
endmodule

// ===== hdl/bisc_checker.sv =====
`timescale 1ns / 1ps
`include "bicubic_image_scaler_core_assert.svh"
module bisc_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic cmd,
  input logic out_valid
);
  import bisc_pkg::*;

  `BISC_ASSERT(a_load_no_busy, (start && !busy && cmd == CMD_LOAD) |=> !busy, "load made busy")
  `BISC_ASSERT(a_compute_busy, (start && !busy && cmd == CMD_COMPUTE) |=> busy, "compute not taken")
  `BISC_ASSERT(a_fall_result, $fell(busy) |-> out_valid, "busy fell without result")
  `BISC_ASSERT(a_single_strobe, out_valid |=> !out_valid, "result strobe longer than a cycle")
  `BISC_NEVER(a_result_idle, out_valid && busy, "result while busy")
endmodule

bind bicubic_image_scaler_core bisc_checker u_bisc_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .out_valid(out_valid)
);
